// ===== rtl/bnht_pkg.sv =====
package bnht_pkg;

    localparam int INPUTS   = 13;
    localparam int CNT_W    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
    localparam int W_W      = 16;
    localparam int SUM_W    = W_W + $clog2(INPUTS);
    localparam int LR_W     = 10;
    localparam int GAIN_W   = 10;
    localparam int CFG_W    = 10;
    localparam int PROD_W   = SUM_W + GAIN_W + 1;
    localparam int IDX_SHIFT = 12;
    localparam int TAB_SIZE = 1025;
    localparam int TAB_W    = 15;
    localparam int ROM_AW   = 11;

    localparam logic [LR_W-1:0]   LR_RESET   = 10'd102;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd128;

    typedef enum logic [0:0] {
        REG_LEARNING_RATE = 1'b0,
        REG_SIGMOID_GAIN  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              operation;
        logic [INPUTS-1:0] pattern;
        logic              target;
    } item_word_t;

    typedef struct packed {
        logic signed [15:0] activation;
        logic [15:0]        error;
    } result_word_t;

    typedef enum logic [3:0] {
        DP_NONE = 4'd0,
        DP_LOAD = 4'd1,
        DP_SUM  = 4'd2,
        DP_MUL  = 4'd3,
        DP_IDX  = 4'd4,
        DP_ROM  = 4'd5,
        DP_ACT  = 4'd6,
        DP_SQR  = 4'd7,
        DP_OUT  = 4'd8,
        DP_CLR  = 4'd9,
        DP_UPD  = 4'd10
    } dp_op_t;

    typedef enum logic [2:0] {
        JC_NEXT  = 3'd0,
        JC_GOTO  = 3'd1,
        JC_IN    = 3'd2,
        JC_LOOP  = 3'd3,
        JC_OUT   = 3'd4,
        JC_TRAIN = 3'd5
    } jc_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_IDLE = 4'd0;
    localparam step_t ST_SUM  = 4'd1;
    localparam step_t ST_MUL  = 4'd2;
    localparam step_t ST_IDX  = 4'd3;
    localparam step_t ST_ROM  = 4'd4;
    localparam step_t ST_ACT  = 4'd5;
    localparam step_t ST_SQR  = 4'd6;
    localparam step_t ST_OUT  = 4'd7;
    localparam step_t ST_TRN  = 4'd8;
    localparam step_t ST_UPD  = 4'd9;

    typedef struct packed {
        dp_op_t op;
        jc_t    jc;
        step_t  target;
    } ctrl_t;

    typedef struct packed {
        logic item_fire;
        logic cnt_last;
        logic out_free;
        logic train;
    } cond_t;

    typedef logic [TAB_SIZE-1:0][TAB_W-1:0] tab_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        unique case (s)
            ST_IDLE: c = '{op: DP_LOAD, jc: JC_IN,    target: ST_SUM};
            ST_SUM:  c = '{op: DP_SUM,  jc: JC_LOOP,  target: ST_MUL};
            ST_MUL:  c = '{op: DP_MUL,  jc: JC_NEXT,  target: ST_IDLE};
            ST_IDX:  c = '{op: DP_IDX,  jc: JC_NEXT,  target: ST_IDLE};
            ST_ROM:  c = '{op: DP_ROM,  jc: JC_NEXT,  target: ST_IDLE};
            ST_ACT:  c = '{op: DP_ACT,  jc: JC_NEXT,  target: ST_IDLE};
            ST_SQR:  c = '{op: DP_SQR,  jc: JC_NEXT,  target: ST_IDLE};
            ST_OUT:  c = '{op: DP_OUT,  jc: JC_OUT,   target: ST_TRN};
            ST_TRN:  c = '{op: DP_CLR,  jc: JC_TRAIN, target: ST_IDLE};
            ST_UPD:  c = '{op: DP_UPD,  jc: JC_LOOP,  target: ST_IDLE};
            default: c = '{op: DP_NONE, jc: JC_GOTO,  target: ST_IDLE};
        endcase
        return c;
    endfunction

    // shift-subtract quotient for the table build
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b})
            begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(16384*tanh(k/128)) from r = e^(-k/64) in Q62
    function automatic tab_t tanh_table();
        tab_t         t;
        logic [63:0]  one;
        logic [63:0]  stp;
        logic [63:0]  term;
        logic [63:0]  r;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [127:0] prod;
        int           k;
        one  = 64'd1 << 62;
        stp  = one;
        term = one;
        r    = one;
        t    = '0;
        for (int n = 1; n < 20; n++)
        begin
            term = udiv64(term, 64'd64 * 64'(n));
            if (n % 2 == 1)
                stp = stp - term;
            else
                stp = stp + term;
        end
        for (int hi = 0; hi < 33; hi++)
        begin
            for (int lo = 0; lo < 32; lo++)
            begin
                k = hi * 32 + lo;
                if (k < TAB_SIZE)
                begin
                    num  = (one - r) >> 16;
                    den  = (one + r) >> 16;
                    t[k] = TAB_W'(udiv64(64'd32768 * num + den, 64'd2 * den));
                    prod = {64'd0, r} * {64'd0, stp};
                    r    = prod[125:62];
                end
            end
        end
        return t;
    endfunction

endpackage

// ===== rtl/bnht_seq.sv =====
module bnht_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  bnht_pkg::cond_t cond,
    output bnht_pkg::ctrl_t ctrl
);
    import bnht_pkg::*;

    step_t step_reg;
    step_t step_next;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.jc)
            JC_NEXT:  step_next = step_reg + 4'd1;
            JC_GOTO:  step_next = ctrl.target;
            JC_IN:    step_next = cond.item_fire ? ctrl.target : step_reg;
            JC_LOOP:  step_next = cond.cnt_last ? ctrl.target : step_reg;
            JC_OUT:   step_next = cond.out_free ? ctrl.target : step_reg;
            JC_TRAIN: step_next = cond.train ? step_reg + 4'd1 : ctrl.target;
            default:  step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// ===== rtl/bipolar_neuron_hebb_train.sv =====
// One neuron, 13 bipolar inputs, tanh-shaped output, Hebbian weight update.
// item channel: item_valid/item_stall carry an item word (operation, pattern,
// target). result channel: result_valid/result_stall carry one result word
// (activation Q1.14, error Q3.13) for every item.
// Config: cfg_en writes cfg_data into register cfg_index (0 learning rate,
// 1 sigmoid gain) at the clock edge; write only while the block is idle.
// Flow: one item at a time under a microcoded step counter. The net sum
// walks the 13 weights one per cycle, then the multiply, table index, table
// read, sign, square and output steps follow in that order; the output step
// waits while the result register is full. An evaluate item then frees the
// input; a training item first walks the 13 weights again to update them.
// The 1025-entry activation table is a ROM with a registered read port.
// Reset clears all weights to zero, sets learning rate 102 and gain 128,
// and empties the result register.
// A stalled result holds in the output register; the next item runs up to
// its output step and waits there until the register is free.
module bipolar_neuron_hebb_train (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  bnht_pkg::item_word_t       item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output bnht_pkg::result_word_t     result,
    input  logic                       cfg_en,
    input  bnht_pkg::reg_idx_t         cfg_index,
    input  logic [bnht_pkg::CFG_W-1:0] cfg_data
);
    import bnht_pkg::*;

    localparam tab_t TANH_ROM = tanh_table();
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(INPUTS - 1);

    ctrl_t ctrl;
    cond_t cond;

    logic [LR_W-1:0]          lr_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic signed [W_W-1:0]    weights_reg [INPUTS];
    logic signed [W_W-1:0]    w_upd_next;
    item_word_t               item_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [ROM_AW-1:0]        rom_addr_reg;
    logic [ROM_AW-1:0]        rom_addr_next;
    logic                     neg_reg;
    logic                     neg_next;
    logic [TAB_W-1:0]         rom_q_reg;
    logic signed [15:0]       y_reg;
    logic signed [15:0]       y_next;
    logic [31:0]              sq_reg;
    logic [31:0]              sq_next;
    result_word_t             result_reg;
    logic                     result_valid_reg;

    logic                     item_fire;
    logic                     out_free;
    logic signed [W_W-1:0]    w_cur;
    logic                     bit_cur;
    logic signed [SUM_W-1:0]  w_ext;
    logic signed [PROD_W-IDX_SHIFT-1:0] q;
    logic [15:0]              y_mag;
    logic signed [16:0]       t17;
    logic signed [16:0]       d;
    logic signed [33:0]       sq_full;
    logic signed [W_W:0]      w17;
    logic signed [W_W:0]      nw17;

    bnht_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    assign item_stall   = (ctrl.op != DP_LOAD);
    assign item_fire    = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign cond.item_fire = item_fire;
    assign cond.cnt_last  = (cnt_reg == CNT_LAST);
    assign cond.out_free  = out_free;
    assign cond.train     = item_reg.operation;

    assign w_cur   = weights_reg[cnt_reg];
    assign bit_cur = item_reg.pattern[cnt_reg];
    assign w_ext   = {{(SUM_W-W_W){w_cur[W_W-1]}}, w_cur};

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        case (ctrl.op)
            DP_LOAD:
            begin
                cnt_next = '0;
                acc_next = '0;
            end
            DP_SUM, DP_UPD:
            begin
                cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
                if (ctrl.op == DP_SUM)
                    acc_next = bit_cur ? acc_reg + w_ext : acc_reg - w_ext;
            end
            DP_CLR:
                cnt_next = '0;
            default:
                cnt_next = cnt_reg;
        endcase
    end

    assign prod_next = PROD_W'($signed({1'b0, gain_reg})) * PROD_W'(acc_reg);

    always_comb
    begin
        q = prod_reg[PROD_W-1:IDX_SHIFT];
        if (q < -1024)
        begin
            neg_next      = 1'b1;
            rom_addr_next = ROM_AW'(1024);
        end
        else if (q > 1023)
        begin
            neg_next      = 1'b0;
            rom_addr_next = ROM_AW'(1023);
        end
        else
        begin
            neg_next      = q[PROD_W-IDX_SHIFT-1];
            rom_addr_next = neg_next ? ROM_AW'(-q) : q[ROM_AW-1:0];
        end
    end

    assign y_mag   = {1'b0, rom_q_reg};
    assign y_next  = neg_reg ? -$signed(y_mag) : $signed(y_mag);
    assign t17     = item_reg.target ? 17'sd16384 : -17'sd16384;
    assign d       = t17 - {y_reg[15], y_reg};
    assign sq_full = 34'(d) * 34'(d);
    assign sq_next = sq_full[31:0];

    assign w17  = {w_cur[W_W-1], w_cur};
    assign nw17 = (bit_cur == item_reg.target) ? w17 + $signed({7'd0, lr_reg})
                                               : w17 - $signed({7'd0, lr_reg});
    assign w_upd_next = (nw17[W_W] != nw17[W_W-1])
                        ? (nw17[W_W] ? 16'sh8000 : 16'sh7FFF)
                        : nw17[W_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg           <= LR_RESET;
            gain_reg         <= GAIN_RESET;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < INPUTS; i++)
                weights_reg[i] <= '0;
        end
        else
        begin
            if (cfg_en)
            begin
                unique case (cfg_index)
                    REG_LEARNING_RATE: lr_reg   <= cfg_data[LR_W-1:0];
                    REG_SIGMOID_GAIN:  gain_reg <= cfg_data[GAIN_W-1:0];
                    default:           lr_reg   <= lr_reg;
                endcase
            end
            cnt_reg <= cnt_next;
            if (ctrl.op == DP_UPD)
                weights_reg[cnt_reg] <= w_upd_next;
            if (ctrl.op == DP_OUT && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            item_reg <= item;
        acc_reg <= acc_next;
        if (ctrl.op == DP_MUL)
            prod_reg <= prod_next;
        if (ctrl.op == DP_IDX)
        begin
            rom_addr_reg <= rom_addr_next;
            neg_reg      <= neg_next;
        end
        if (ctrl.op == DP_ROM)
            rom_q_reg <= TANH_ROM[rom_addr_reg];
        if (ctrl.op == DP_ACT)
            y_reg <= y_next;
        if (ctrl.op == DP_SQR)
            sq_reg <= sq_next;
        if (ctrl.op == DP_OUT && out_free)
        begin
            result_reg.activation <= y_reg;
            result_reg.error      <= sq_reg[30:15] + {15'd0, sq_reg[14]};
        end
    end

    a_accept_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> (ctrl.op == DP_SUM))
        else $error("accepted item did not start the sum walk");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(ctrl.op == DP_OUT))
        else $error("result raised outside the output step");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("weight counter out of range");

endmodule

// ===== tb/bnht_neuron_check.sv =====
module bnht_neuron_check (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic                       item_stall,
    input  bnht_pkg::item_word_t       item,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  bnht_pkg::result_word_t     result,
    input  logic                       cfg_en,
    input  bnht_pkg::reg_idx_t         cfg_index,
    input  logic [bnht_pkg::CFG_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         outstanding
);
    import bnht_pkg::*;

    int unsigned           tanh_lut [0:TAB_SIZE-1];
    logic signed [W_W-1:0] weight_q [INPUTS];
    logic [LR_W-1:0]       rate_q;
    logic [GAIN_W-1:0]     gain_q;
    result_word_t          neuron_outputs_q [$];
    result_word_t          oldest;

    function automatic void build_tanh_lut();
        logic [63:0]  one;
        logic [63:0]  decay;
        logic [63:0]  term;
        logic [63:0]  r;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [127:0] prod;
        one   = 64'd1 << 62;
        decay = one;
        term  = one;
        r     = one;
        for (int n = 1; n < 20; n++)
        begin
            term = term / (64'd64 * 64'(n));
            if (n[0])
                decay = decay - term;
            else
                decay = decay + term;
        end
        for (int k = 0; k < TAB_SIZE; k++)
        begin
            num         = (one - r) >> 16;
            den         = (one + r) >> 16;
            tanh_lut[k] = int'((64'd32768 * num + den) / (64'd2 * den));
            prod        = {64'd0, r} * {64'd0, decay};
            r           = prod[125:62];
        end
    endfunction

    // evaluate, then apply the Hebbian step when training
    function automatic result_word_t neuron_response(input item_word_t w);
        int           acc;
        longint       prod;
        longint       ix;
        int           y;
        longint       d;
        longint       err;
        int           nw;
        result_word_t r;
        acc = 0;
        for (int i = 0; i < INPUTS; i++)
            acc += w.pattern[i] ? int'(weight_q[i]) : -int'(weight_q[i]);
        prod = longint'(gain_q) * longint'(acc);
        ix   = prod >>> IDX_SHIFT;
        if (ix < -1024)
            ix = -1024;
        if (ix > 1023)
            ix = 1023;
        y   = (ix >= 0) ? int'(tanh_lut[ix]) : -int'(tanh_lut[-ix]);
        d   = longint'(w.target ? 16384 : -16384) - longint'(y);
        err = (d * d + 64'sd16384) >>> 15;
        if (w.operation)
        begin
            for (int i = 0; i < INPUTS; i++)
            begin
                nw = int'(weight_q[i]) +
                     ((w.pattern[i] == w.target) ? int'(rate_q) : -int'(rate_q));
                if (nw > 32767)
                    nw = 32767;
                if (nw < -32768)
                    nw = -32768;
                weight_q[i] = nw[W_W-1:0];
            end
        end
        r.activation = y[15:0];
        r.error      = err[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        build_tanh_lut();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_q = LR_RESET;
            gain_q = GAIN_RESET;
            for (int i = 0; i < INPUTS; i++)
                weight_q[i] = '0;
            neuron_outputs_q.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_en)
            begin
                if (cfg_index == REG_LEARNING_RATE)
                    rate_q = cfg_data[LR_W-1:0];
                else if (cfg_index == REG_SIGMOID_GAIN)
                    gain_q = cfg_data[GAIN_W-1:0];
            end
            if (item_valid && !item_stall)
                neuron_outputs_q.push_back(neuron_response(item));
            if (result_valid && !result_stall)
            begin
                if (neuron_outputs_q.size() == 0)
                    report_mismatch("unrequested result word", result.activation, 0);
                else
                begin
                    oldest = neuron_outputs_q.pop_front();
                    if (result.activation !== oldest.activation)
                        report_mismatch("activation", result.activation, oldest.activation);
                    if (result.error !== oldest.error)
                        report_mismatch("error", result.error, oldest.error);
                end
            end
            outstanding <= neuron_outputs_q.size();
        end
    end

endmodule

// ===== tb/bipolar_neuron_hebb_train_tb.sv =====
module bipolar_neuron_hebb_train_tb;
    import bnht_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    item_word_t       item;
    logic             result_valid;
    logic             result_stall;
    result_word_t     result;
    logic             cfg_en;
    reg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int         fail_count;
    int         outstanding;
    int         snd_idle;
    int         rcv_idle;
    int         hold_req;
    int         hold_seen;
    int         hold_left;
    int         cycles;
    item_word_t drill [4];

    bipolar_neuron_hebb_train DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bnht_neuron_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("bipolar_neuron_hebb_train_tb: FAIL");
        $finish;
    end

    initial
    begin
        result_stall = 1'b0;
        hold_seen    = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    task automatic send_word(input item_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic send_op(input logic op, input logic [INPUTS-1:0] pat, input logic tgt);
        send_word('{operation: op, pattern: pat, target: tgt});
    endtask

    // drop valid, then wait for the last word and the tail of a weight update
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_en    <= 1'b0;
    endtask

    // consistent drill[0..2] push the weights to saturation; drill[3] is random
    function automatic void pick_drill();
        logic [INPUTS-1:0] p;
        p = INPUTS'($urandom_range(8191));
        drill[0] = '{operation: 1'b1, pattern: p, target: 1'b1};
        drill[1] = '{operation: 1'b1, pattern: ~p, target: 1'b0};
        drill[2] = '{operation: 1'b1, pattern: p ^ (INPUTS'(1) << $urandom_range(INPUTS-1)),
                     target: 1'b1};
        drill[3] = '{operation: 1'b1, pattern: INPUTS'($urandom_range(8191)),
                     target: 1'($urandom_range(1))};
    endfunction

    function automatic item_word_t rand_item();
        item_word_t w;
        if ($urandom_range(99) < 60)
        begin
            w = drill[$urandom_range(3)];
            w.operation = ($urandom_range(99) < 85);
        end
        else
        begin
            w.operation = 1'($urandom_range(1));
            w.pattern   = INPUTS'($urandom_range(8191));
            w.target    = 1'($urandom_range(1));
        end
        return w;
    endfunction

    task automatic run_random(input int n);
        repeat (n) send_word(rand_item());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_en     = 1'b0;
        cfg_index  = REG_LEARNING_RATE;
        cfg_data   = '0;
        snd_idle   = 25;
        rcv_idle   = 53;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_op(1'b0, 13'h0000, 1'b0);
        send_op(1'b0, 13'h1fff, 1'b1);
        send_op(1'b1, 13'h1fff, 1'b1);
        send_op(1'b0, 13'h1fff, 1'b1);
        send_op(1'b0, 13'h0000, 1'b1);
        send_op(1'b1, 13'h0000, 1'b0);
        send_op(1'b1, 13'h1555, 1'b1);
        send_op(1'b1, 13'h0aaa, 1'b0);
        send_op(1'b0, 13'h1234, 1'b0);
        drain();

        write_reg(REG_SIGMOID_GAIN, 10'd0);
        send_op(1'b0, 13'h1fff, 1'b1);
        send_op(1'b1, 13'h1fff, 1'b0);
        send_op(1'b0, 13'h0000, 1'b0);
        drain();

        write_reg(REG_LEARNING_RATE, 10'd1023);
        write_reg(REG_SIGMOID_GAIN, 10'd1023);
        repeat (6) send_op(1'b1, 13'h1fff, 1'b1);
        send_op(1'b0, 13'h1fff, 1'b1);
        send_op(1'b0, 13'h1fff, 1'b0);
        send_op(1'b0, 13'h0000, 1'b0);
        send_op(1'b0, 13'h0000, 1'b1);
        drain();

        pick_drill();
        hold_req++;
        run_random(170);
        drain();

        snd_idle = 53;
        rcv_idle = 25;
        write_reg(REG_LEARNING_RATE, 10'd0);
        write_reg(REG_SIGMOID_GAIN, 10'd1);
        pick_drill();
        run_random(80);
        drain();
        write_reg(REG_LEARNING_RATE, 10'd1);
        write_reg(REG_SIGMOID_GAIN, 10'h200);
        pick_drill();
        run_random(90);
        drain();

        snd_idle = 0;
        rcv_idle = 0;
        repeat (4)
        begin
            write_reg(REG_LEARNING_RATE, CFG_W'($urandom_range(1023)));
            write_reg(REG_SIGMOID_GAIN, CFG_W'($urandom_range(1023)));
            pick_drill();
            run_random(40);
            drain();
        end

        if (fail_count == 0)
            $display("bipolar_neuron_hebb_train_tb: PASS");
        else
            $display("bipolar_neuron_hebb_train_tb: FAIL");
        $finish;
    end

endmodule
